@@ design/slsw_pkg.sv @@
// ----------------------------------------------------------------------------
// slsw_pkg
// Shared widths, constants and the slew step of the slew-limited square wave.
// ----------------------------------------------------------------------------
`default_nettype none

package slsw_pkg;

  localparam int ELAPSED_W = 20;
  localparam int PERIOD_W  = 24;
  localparam int LEVEL_W   = 8;
  localparam int EDGE_W    = 16;
  localparam int PHASE_W   = 26;
  localparam int STEP_W    = 9;

  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_PERIOD = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOW_PERIOD  = 1'b1;

  localparam int SLEW_DIV = 88;
  localparam logic [PERIOD_W-1:0] SLEW_LIM = PERIOD_W'(SLEW_DIV * 256);
  localparam logic [LEVEL_W-1:0]  LEVEL_MAX = 8'hff;

  // floor(x / 88) = floor((x >> 3) * 2979 >> 15) for x <= 88 * 256
  localparam int RECIP_W     = 12;
  localparam int RECIP_SHIFT = 15;
  localparam logic [RECIP_W-1:0] RECIP_11 = 12'd2979;

  typedef logic [LEVEL_W-1:0] level_t;

  function automatic level_t slew_step(input level_t lvl, input logic pol,
                                       input logic [PERIOD_W-1:0] span);
    logic [2*RECIP_W-1:0] prod;
    logic [STEP_W-1:0]    steps;
    logic [STEP_W:0]      up;
    level_t               res;
    prod  = span[RECIP_W+2:3] * RECIP_11;
    steps = prod[RECIP_SHIFT+STEP_W-1:RECIP_SHIFT];
    up    = {2'b00, lvl} + {1'b0, steps};
    if (span > SLEW_LIM) begin
      res = pol ? LEVEL_MAX : '0;
    end else if (pol) begin
      res = (up > {2'b00, LEVEL_MAX}) ? LEVEL_MAX : up[LEVEL_W-1:0];
    end else begin
      res = (steps >= {1'b0, lvl}) ? '0 : (lvl - steps[LEVEL_W-1:0]);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ design/slew_limited_square_wave.sv @@
// ----------------------------------------------------------------------------
// slew_limited_square_wave
// 1-bit sound channel whose level slews toward the current wave polarity.
// ----------------------------------------------------------------------------
// Each input transaction carries the ns elapsed since the previous one; the
// block answers with one output transaction holding the level, polarity and
// edge count after that span. A zero span goes straight to the done state; a
// nonzero span takes a slew step and, when both half-periods are nonzero, a
// phase step and a check, then a slew step and a check per half-period expiry
// inside the span, as a small sequencer walks them one at a time through a
// single shared phase adder and the slew unit. A full output register holds
// the sequencer in the done state until out_ready frees it. in_ready is high
// whenever the sequencer is idle, which it is once the result is loaded; a
// finished result waits in the output register while the next is accepted.
`default_nettype none

module slew_limited_square_wave (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire logic [slsw_pkg::ELAPSED_W-1:0]      in_elapsed_ns,
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      logic [slsw_pkg::LEVEL_W-1:0]        out_level,
  output      logic                                out_polarity,
  output      logic [slsw_pkg::EDGE_W-1:0]         out_edge_count,
  input  wire logic                                cfg_valid,
  output      logic                                cfg_ready,
  input  wire logic [slsw_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [slsw_pkg::PERIOD_W-1:0]       cfg_wdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SLEW  = 3'd1;
  localparam logic [2:0] S_PHASE = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam int PW = slsw_pkg::PHASE_W;
  localparam int DW = slsw_pkg::PERIOD_W;

  logic [2:0]                      state_r, state_nxt;
  logic                            loop_r, loop_nxt;
  logic [DW-1:0]                   span_r, span_nxt;
  logic [DW-1:0]                   high_r, low_r;
  slsw_pkg::level_t                level_r, level_nxt;
  logic                            pol_r, pol_nxt;
  logic signed [PW-1:0]            phase_r, phase_nxt;
  logic [slsw_pkg::EDGE_W-1:0]     edge_r, edge_nxt;
  logic                            out_valid_r;
  slsw_pkg::level_t                out_level_r;
  logic                            out_pol_r;
  logic [slsw_pkg::EDGE_W-1:0]     out_edge_r;

  logic                            periods_on;
  logic [DW-1:0]                   per;
  logic signed [PW-1:0]            addend;
  logic signed [PW-1:0]            sum;
  logic [PW-1:0]                   neg_phase;
  logic                            expired;
  logic                            out_free;

  assign in_ready       = (state_r == S_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_level      = out_level_r;
  assign out_polarity   = out_pol_r;
  assign out_edge_count = out_edge_r;

  assign periods_on = (high_r != '0) && (low_r != '0);
  assign per        = pol_r ? low_r : high_r;
  assign expired    = phase_r[PW-1] || (phase_r == '0);
  assign neg_phase  = PW'(0) - phase_r;
  assign out_free   = !out_valid_r || out_ready;

  // shared phase adder: subtract the span, or add the next half-period
  always_comb begin
    if (state_r == S_PHASE) begin
      addend = ~{2'b00, span_r} + PW'(1);
    end else begin
      addend = {2'b00, per};
    end
    sum = phase_r + addend;
  end

  always_comb begin
    state_nxt = state_r;
    loop_nxt  = loop_r;
    span_nxt  = span_r;
    level_nxt = level_r;
    pol_nxt   = pol_r;
    phase_nxt = phase_r;
    edge_nxt  = edge_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          span_nxt  = {{(DW-slsw_pkg::ELAPSED_W){1'b0}}, in_elapsed_ns};
          loop_nxt  = 1'b0;
          state_nxt = (in_elapsed_ns == '0) ? S_DONE : S_SLEW;
        end
      end
      S_SLEW: begin
        level_nxt = slsw_pkg::slew_step(level_r, pol_r, span_r);
        if (loop_r) begin
          state_nxt = S_CHECK;
        end else begin
          state_nxt = periods_on ? S_PHASE : S_DONE;
        end
      end
      S_PHASE: begin
        phase_nxt = sum;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (expired) begin
          pol_nxt   = ~pol_r;
          edge_nxt  = edge_r + 1'b1;
          phase_nxt = sum;
          span_nxt  = (!sum[PW-1] && sum != '0) ? neg_phase[DW-1:0] : per;
          loop_nxt  = 1'b1;
          state_nxt = S_SLEW;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loop_r      <= 1'b0;
      level_r     <= '0;
      pol_r       <= 1'b0;
      phase_r     <= '0;
      edge_r      <= '0;
      high_r      <= '0;
      low_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      loop_r  <= loop_nxt;
      level_r <= level_nxt;
      pol_r   <= pol_nxt;
      phase_r <= phase_nxt;
      edge_r  <= edge_nxt;
      if (cfg_valid) begin
        if (cfg_index == slsw_pkg::CFG_HIGH_PERIOD) begin
          high_r <= cfg_wdata;
        end
        if (cfg_index == slsw_pkg::CFG_LOW_PERIOD) begin
          low_r <= cfg_wdata;
        end
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    span_r <= span_nxt;
    if (state_r == S_DONE && out_free) begin
      out_level_r <= level_r;
      out_pol_r   <= pol_r;
      out_edge_r  <= edge_r;
    end
  end

  a_zero_span_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_elapsed_ns == '0) |=> (state_r == S_DONE))
    else $error("zero span did not go straight to result");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r <= $signed(PW'(1 << DW))) && (phase_r >= -$signed(PW'(1 << 20))))
    else $error("phase counter out of range");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside of completion");

  a_edge_with_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    (edge_r != $past(edge_r)) |-> (pol_r != $past(pol_r)))
    else $error("edge count moved without a polarity toggle");

endmodule

`default_nettype wire
